// ----- src/fir_filter_with_gain_unit_macros.svh -----
// Assertion macros for the FIR filter with gain unit.
// Used by the checker; needs i_clk and i_rst_n in scope.
`ifndef FIR_FILTER_WITH_GAIN_UNIT_MACROS_SVH
`define FIR_FILTER_WITH_GAIN_UNIT_MACROS_SVH

// same-cycle implication
`define FGU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fgu assertion failed");

// next-cycle implication
`define FGU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fgu assertion failed");

`endif

// ----- src/fgu_pkg.sv -----
// Package for the FIR filter with gain unit: field widths, defaults, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fgu_pkg;

    localparam int unsigned TAPS_DEF        = 32;
    localparam int unsigned SAMPLE_BITS_DEF = 24;
    localparam int unsigned COEF_FRAC_DEF   = 16;

    localparam int unsigned COEF_W    = 18;
    localparam int unsigned CIDX_W    = 5;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned GAIN_FRAC = 16;

    localparam logic [GAIN_W-1:0] GAIN_RST = 17'd65536;

    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_COEF   = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_GAIN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- src/fgu_store.sv -----
// Synchronous single-port-write, single-port-read memory with registered read data.
// Per-entry valid bits make unwritten entries read as RST_VAL. Uses fgu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgu_store #(
    parameter int unsigned             DEPTH   = fgu_pkg::TAPS_DEF,
    parameter int unsigned             WIDTH   = fgu_pkg::COEF_W,
    parameter logic [WIDTH-1:0]        RST_VAL = '0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_q;
    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : RST_VAL;

endmodule

`default_nettype wire

// ----- src/fir_filter_with_gain_unit.sv -----
// FIR filter with output gain. After a filter transfer the unit does one multiply-accumulate
// per tap from the delay-line and coefficient memories, then the gain step, then registers the
// result; the next input is taken after that. Coefficient writes: one per cycle while idle.
// Reset (synchronous, active low) clears at once: delay line reads zero, coefficients
// read (1 << COEF_FRAC_BITS) / TAPS, gain is unity, write position zero.
// Depends on fgu_pkg and fgu_store.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_with_gain_unit #(
    parameter int unsigned TAPS           = fgu_pkg::TAPS_DEF,
    parameter int unsigned SAMPLE_BITS    = fgu_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned COEF_FRAC_BITS = fgu_pkg::COEF_FRAC_DEF,
    localparam int unsigned IN_W  = ((SAMPLE_BITS + fgu_pkg::CIDX_W + fgu_pkg::COEF_W + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [fgu_pkg::GAIN_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // sample_in, coef_index, coef_value, zero pad
    input  wire logic [IN_W-1:0]             i_s_axis_tdata,
    // command
    input  wire logic                        i_s_axis_tuser,
    // block_end_in
    input  wire logic                        i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // sample_out, zero pad
    output logic      [OUT_W-1:0]            o_m_axis_tdata,
    // block_end_out
    output logic                             o_m_axis_tlast
);

    localparam int unsigned IDX_W  = $clog2(TAPS);
    localparam int unsigned COEF_W = fgu_pkg::COEF_W;
    localparam int unsigned GFRAC  = fgu_pkg::GAIN_FRAC;
    localparam int unsigned GAIN_W = fgu_pkg::GAIN_W;
    localparam int unsigned P_W    = SAMPLE_BITS + COEF_W;
    localparam int unsigned ACC_RAW = P_W + IDX_W;
    localparam int unsigned ACC_W  = (ACC_RAW > COEF_FRAC_BITS + GFRAC + 1) ?
                                     ACC_RAW : COEF_FRAC_BITS + GFRAC + 1;
    localparam int unsigned HI_W   = ACC_W - COEF_FRAC_BITS - GFRAC;
    localparam int unsigned HP_W   = HI_W + GAIN_W + 1;
    localparam int unsigned LP_W   = GFRAC + GAIN_W;
    localparam int unsigned Y_W    = (HP_W + 1 > SAMPLE_BITS + 1) ? HP_W + 1 : SAMPLE_BITS + 1;

    localparam logic [COEF_W-1:0]     COEF_RST = COEF_W'((64'd1 << COEF_FRAC_BITS) / TAPS);
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(TAPS - 1);

    fgu_pkg::t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] s_sample;
    logic [fgu_pkg::CIDX_W-1:0] s_cidx;
    logic [COEF_W-1:0]      s_coef;
    logic                   s_xfer, s_filt_xfer, s_coef_wr;

    logic                   rd_en, gain_en, out_load, out_free, s_ready;

    logic [IDX_W-1:0]       r_wp, r_rd_ptr, r_cnt, wp_next;
    logic [GAIN_W-1:0]      r_gain;
    logic                   r_blk;
    logic                   r_rd_v, r_prod_v;
    logic signed [P_W-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [HP_W-1:0] r_hi_prod;
    logic [LP_W-1:0]        r_lo_prod;
    logic                   r_out_valid, r_out_last;
    logic [OUT_W-1:0]       r_out_data;

    logic [SAMPLE_BITS-1:0] hist_rd;
    logic [COEF_W-1:0]      coef_rd;
    logic signed [HI_W-1:0] acc_hi;
    logic signed [Y_W-1:0]  y, y_sat;

    assign s_sample    = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_cidx      = i_s_axis_tdata[SAMPLE_BITS+fgu_pkg::CIDX_W-1:SAMPLE_BITS];
    assign s_coef      = i_s_axis_tdata[SAMPLE_BITS+fgu_pkg::CIDX_W+COEF_W-1:
                                        SAMPLE_BITS+fgu_pkg::CIDX_W];
    assign s_xfer      = i_s_axis_tvalid && s_ready;
    assign s_filt_xfer = s_xfer && (i_s_axis_tuser == fgu_pkg::CMD_FILTER);
    assign s_coef_wr   = s_xfer && (i_s_axis_tuser == fgu_pkg::CMD_COEF)
                         && (int'(s_cidx) < int'(TAPS));
    assign wp_next     = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
    assign out_free    = !r_out_valid || i_m_axis_tready;

    fgu_store #(
        .DEPTH   (TAPS),
        .WIDTH   (SAMPLE_BITS),
        .RST_VAL ('0)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s_filt_xfer),
        .i_wr_addr (r_wp),
        .i_wr_data (s_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (hist_rd)
    );

    fgu_store #(
        .DEPTH   (TAPS),
        .WIDTH   (COEF_W),
        .RST_VAL (COEF_RST)
    ) u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s_coef_wr),
        .i_wr_addr (IDX_W'(s_cidx)),
        .i_wr_data (s_coef),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt),
        .o_rd_data (coef_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            fgu_pkg::ST_IDLE: begin
                if (s_filt_xfer) n_state = fgu_pkg::ST_MAC;
            end
            fgu_pkg::ST_MAC: begin
                if (r_cnt == LAST_IDX) n_state = fgu_pkg::ST_DRAIN;
            end
            fgu_pkg::ST_DRAIN: begin
                if (!r_rd_v && !r_prod_v) n_state = fgu_pkg::ST_GAIN;
            end
            fgu_pkg::ST_GAIN: begin
                n_state = fgu_pkg::ST_OUT;
            end
            fgu_pkg::ST_OUT: begin
                if (out_free) n_state = fgu_pkg::ST_IDLE;
            end
            default: begin
                n_state = fgu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        gain_en  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            fgu_pkg::ST_IDLE:  s_ready  = 1'b1;
            fgu_pkg::ST_MAC:   rd_en    = 1'b1;
            fgu_pkg::ST_GAIN:  gain_en  = 1'b1;
            fgu_pkg::ST_OUT:   out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fgu_pkg::ST_IDLE;
            r_wp        <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= '0;
            r_gain      <= fgu_pkg::GAIN_RST;
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= rd_en;
            r_prod_v <= r_rd_v;
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            if (s_filt_xfer) begin
                r_wp     <= wp_next;
                r_rd_ptr <= wp_next;
                r_cnt    <= '0;
            end else if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
                r_cnt    <= r_cnt + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    assign acc_hi = signed'(r_acc[ACC_W-1:COEF_FRAC_BITS+GFRAC]);

    always_ff @(posedge i_clk) begin
        if (s_filt_xfer) begin
            r_blk <= i_s_axis_tlast;
        end
        if (r_rd_v) begin
            r_prod <= signed'(hist_rd) * signed'(coef_rd);
        end
        if (s_filt_xfer) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (gain_en) begin
            r_hi_prod <= acc_hi * signed'({1'b0, r_gain});
            r_lo_prod <= r_acc[COEF_FRAC_BITS+GFRAC-1:COEF_FRAC_BITS] * r_gain;
        end
        if (out_load) begin
            r_out_data <= OUT_W'(y_sat[SAMPLE_BITS-1:0]);
            r_out_last <= r_blk;
        end
    end

    always_comb begin
        y = Y_W'(r_hi_prod) + Y_W'(signed'({1'b0, r_lo_prod[LP_W-1:GFRAC]}));
        if (y > Y_MAX) begin
            y_sat = Y_MAX;
        end else if (y < Y_MIN) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = y;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- src/fgu_checker.sv -----
// Port-level checker for fir_filter_with_gain_unit, attached by bind.
// Depends on fgu_pkg and fir_filter_with_gain_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_filter_with_gain_unit_macros.svh"

module fgu_checker #(
    parameter int unsigned OUT_W = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    input  wire logic             o_s_axis_tready,
    input  wire logic             i_s_axis_tuser,
    input  wire logic             o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    input  wire logic [OUT_W-1:0] o_m_axis_tdata
);

    logic s_filt_xfer;
    logic s_coef_xfer;
    logic m_stall;

    assign s_filt_xfer = i_s_axis_tvalid && o_s_axis_tready
                         && (i_s_axis_tuser == fgu_pkg::CMD_FILTER);
    assign s_coef_xfer = i_s_axis_tvalid && o_s_axis_tready
                         && (i_s_axis_tuser == fgu_pkg::CMD_COEF);
    assign m_stall     = o_m_axis_tvalid && !i_m_axis_tready;

    `FGU_ASSERT_NEXT(a_busy_after_filter, s_filt_xfer, !o_s_axis_tready)
    `FGU_ASSERT_NEXT(a_idle_after_coef, s_coef_xfer, o_s_axis_tready)
    `FGU_ASSERT_IMPL(a_result_while_busy, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))
    `FGU_ASSERT_NEXT(a_hold_stalled, m_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind fir_filter_with_gain_unit fgu_checker #(
    .OUT_W (OUT_W)
) u_fgu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ----- tb/tb_fir_filter_with_gain_unit.sv -----
// Testbench for fir_filter_with_gain_unit: directed and random sample/coefficient transfers,
// with a scoreboard class that predicts each filtered sample and checks the output stream.
// Depends on fgu_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_fir_filter_with_gain_unit;

    localparam int unsigned SW            = fgu_pkg::SAMPLE_BITS_DEF;
    localparam int unsigned TAPS_DEF      = fgu_pkg::TAPS_DEF;
    localparam int unsigned COEF_FRAC_DEF = fgu_pkg::COEF_FRAC_DEF;
    localparam int unsigned CIDX_W        = fgu_pkg::CIDX_W;
    localparam int unsigned COEF_W        = fgu_pkg::COEF_W;
    localparam int unsigned GAIN_W        = fgu_pkg::GAIN_W;
    localparam int unsigned GAIN_FRAC     = fgu_pkg::GAIN_FRAC;
    localparam logic [GAIN_W-1:0] GAIN_RST = fgu_pkg::GAIN_RST;
    localparam int unsigned IN_W  = ((SW + CIDX_W + COEF_W + 7) / 8) * 8;
    localparam int unsigned OUT_W = ((SW + 7) / 8) * 8;
    localparam int          LIMIT = 1_000_000;
    localparam int          RAND_ITEMS = 1400;
    localparam int          HOLD_AT_RESULTS = 300;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam longint      SMP_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint      SMP_MIN = -SMP_MAX - 1;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          block_end;
    } t_filtered;

    class fir_scoreboard;
        logic signed [SW-1:0]     hist_buf [TAPS_DEF];
        logic signed [COEF_W-1:0] coefs [TAPS_DEF];
        logic [CIDX_W-1:0]        wr_pos;
        logic [GAIN_W-1:0]        gain;
        t_filtered                filtered_q [$];
        int                       errors;
        int                       results_seen;

        function new();
            for (int k = 0; k < TAPS_DEF; k++) begin
                hist_buf[k] = '0;
                coefs[k] = COEF_W'((1 << COEF_FRAC_DEF) / TAPS_DEF);
            end
            wr_pos = '0;
            gain = GAIN_RST;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_gain(logic [GAIN_W-1:0] g);
            gain = g;
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

        function void note_input(fgu_pkg::t_cmd cmd, logic [SW-1:0] smp, logic last,
                                 logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] cv);
            longint    acc;
            longint    filt;
            longint    y;
            t_filtered r;
            if (cmd == fgu_pkg::CMD_COEF) begin
                if (idx < TAPS_DEF) coefs[idx] = cv;
                return;
            end
            hist_buf[wr_pos] = smp;
            wr_pos = CIDX_W'((int'(wr_pos) + 1) % TAPS_DEF);
            acc = 0;
            // oldest sample meets coefficient 0
            for (int k = 0; k < TAPS_DEF; k++)
                acc += longint'(hist_buf[(int'(wr_pos) + k) % TAPS_DEF]) * longint'(coefs[k]);
            filt = acc >>> COEF_FRAC_DEF;
            y = (filt * longint'(gain)) >>> GAIN_FRAC;
            if (y > SMP_MAX) y = SMP_MAX;
            if (y < SMP_MIN) y = SMP_MIN;
            r.sample = y[SW-1:0];
            r.block_end = last;
            filtered_q.push_back(r);
        endfunction

        function void check_result(logic [SW-1:0] smp, logic last);
            t_filtered e;
            results_seen++;
            if (filtered_q.size() == 0) begin
                $error("unexpected result: sample_out %0d block_end_out %0b",
                       $signed(smp), last);
                errors++;
                return;
            end
            e = filtered_q.pop_front();
            if (e.sample !== smp) begin
                $error("sample_out mismatch: expected %0d actual %0d",
                       $signed(e.sample), $signed(smp));
                errors++;
            end
            if (e.block_end !== last) begin
                $error("block_end_out mismatch: expected %0b actual %0b", e.block_end, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [GAIN_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              s_tlast = 1'b0;
    logic              m_tready = 1'b0;
    wire               s_tready;
    wire               m_tvalid;
    wire [OUT_W-1:0]   m_tdata;
    wire               m_tlast;

    fir_filter_with_gain_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    fir_scoreboard sb = new();
    int burst_left = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata[SW-1:0], m_tlast);
    end

    // receiver: changing stall modes, plus one long hold-off to back up the input
    initial begin
        int  hold;
        int  mode_left;
        int  ready_pct;
        bit  long_done;
        hold = 0;
        mode_left = 0;
        ready_pct = 100;
        long_done = 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 128);
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    default: ready_pct = 20;
                endcase
            end
            mode_left--;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!long_done && sb.results_seen >= HOLD_AT_RESULTS) begin
                long_done = 1'b1;
                hold = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    task automatic send_item(input fgu_pkg::t_cmd cmd, input logic [SW-1:0] smp,
                             input logic last, input logic [CIDX_W-1:0] idx,
                             input logic [COEF_W-1:0] cv);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tlast <= last;
        s_tdata <= IN_W'({cv, idx, smp});
        do @(posedge clk); while (!s_tready);
        sb.note_input(cmd, smp, last, idx, cv);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic filter_sample(input logic [SW-1:0] smp, input logic last);
        send_item(fgu_pkg::CMD_FILTER, smp, last, CIDX_W'($urandom()), COEF_W'($urandom()));
    endtask

    task automatic load_coef(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] cv);
        send_item(fgu_pkg::CMD_COEF, SW'($urandom()), 1'($urandom()), idx, cv);
    endtask

    // gain changes only once the unit has drained
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAPS_DEF + 10) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_gain(g);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 3))
            0: return SW'($urandom());
            1: begin
                v = $urandom_range(0, 2000);
                return SW'(v - 1000);
            end
            2: return $urandom_range(0, 1) ? SW'(SMP_MAX) : SW'(SMP_MIN);
            default: begin
                v = $urandom_range(0, 1 << 20);
                return SW'(v - (1 << 19));
            end
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int v;
        if ($urandom_range(0, 4) == 0) return COEF_W'($urandom());
        v = $urandom_range(0, 8192);
        return COEF_W'(v - 4096);
    endfunction

    initial begin
        int               n;
        logic [GAIN_W-1:0] g;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: moving average, unity gain; then single coefficient overwrites
        filter_sample(SW'(SMP_MAX), 1'b0);
        filter_sample(SW'(SMP_MIN), 1'b1);
        filter_sample('0, 1'b0);
        filter_sample('1, 1'b1);
        load_coef(CIDX_W'(TAPS_DEF - 1), {1'b0, {(COEF_W-1){1'b1}}});
        filter_sample(SW'(SMP_MAX), 1'b0);
        filter_sample(SW'(SMP_MIN), 1'b0);
        load_coef('0, {1'b1, {(COEF_W-1){1'b0}}});
        load_coef(CIDX_W'(15), '0);
        filter_sample(SW'(12345), 1'b1);
        // gain above unity, zero gain, then just above unity
        write_gain(GAIN_MAX);
        filter_sample(SW'(SMP_MAX), 1'b0);
        filter_sample(SW'(SMP_MIN), 1'b1);
        filter_sample(SW'(-3), 1'b0);
        write_gain('0);
        filter_sample(SW'(SMP_MAX), 1'b0);
        filter_sample(SW'(SMP_MIN), 1'b1);
        write_gain(GAIN_RST + 1'b1);
        filter_sample('1, 1'b0);
        filter_sample(SW'(777), 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: g = GAIN_W'($urandom_range(0, GAIN_RST));
                1: g = GAIN_W'($urandom_range(GAIN_RST, GAIN_MAX));
                2: g = GAIN_RST;
                default: g = GAIN_W'($urandom_range(0, GAIN_MAX));
            endcase
            write_gain(g);
            n = 0;
            while (n < RAND_ITEMS / 4) begin
                case ($urandom_range(0, 19))
                    0: begin
                        // full table reload, indices in order
                        for (int k = 0; k < TAPS_DEF; k++) load_coef(CIDX_W'(k), rand_coef());
                        n += TAPS_DEF;
                    end
                    1, 2: begin
                        load_coef(CIDX_W'($urandom_range(0, TAPS_DEF - 1)), rand_coef());
                        n++;
                    end
                    default: begin
                        filter_sample(rand_sample(), $urandom_range(0, 7) == 0);
                        n++;
                    end
                endcase
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAPS_DEF + 10) @(posedge clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
